/* rtl/lzw_pkg.sv */
package lzw_pkg;

  localparam int SYMBOL_COUNT_DEF = 256;
  localparam int DICT_ENTRIES_DEF = 4096;
  localparam int CODE_W = 12;
  localparam int SYM_W = 8;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_EMIT,
    ST_LINK
  } state_t;

endpackage

/* rtl/lzw_if.sv */
interface lzw_in_if;
  logic valid;
  logic ready;
  logic kind;
  logic [lzw_pkg::SYM_W-1:0] symbol;
  modport source (output valid, kind, symbol, input ready);
  modport sink (input valid, kind, symbol, output ready);
endinterface

interface lzw_out_if;
  logic valid;
  logic ready;
  logic [lzw_pkg::CODE_W-1:0] code;
  logic final_res;
  modport source (output valid, code, final_res, input ready);
  modport sink (input valid, code, final_res, output ready);
endinterface

/* rtl/lzw_trie_encoder.sv */
// Channel  Dir  Payload                     Word meaning
// in_ch    in   kind(1) symbol(8)           one byte, or a finish request
// out_ch   out  code(12) final_res(1)       one emitted dictionary code
//
// A data byte that extends the current string passes a head step and then
// a walk step for each trie entry compared on its sibling list. A miss adds
// an emit and a link step, or only the emit step when the dictionary is full
// and is reset instead. A finish goes to the emit step, and the first byte of
// a string only starts it. The sibling walk through dictionary memory, one
// entry per cycle, sets the rate; a new word is taken only in the idle step.
// Reset is synchronous and clears the control state and the root link
// valid bits; the dictionary memories need no clearing pass.
// A stalled output holds the block in its emit step; no word is taken then.
module lzw_trie_encoder #(
  parameter int SYMBOL_COUNT = lzw_pkg::SYMBOL_COUNT_DEF,
  parameter int DICT_ENTRIES = lzw_pkg::DICT_ENTRIES_DEF
) (
  input logic clk,
  input logic rst,
  lzw_in_if.sink in_ch,
  lzw_out_if.source out_ch
);

  localparam int IDXW = $clog2(DICT_ENTRIES);
  localparam int LNKW = IDXW + 1;
  localparam int RW = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT) : 1;

  // Dictionary memories; a link carries a present bit above the index.
  logic [lzw_pkg::SYM_W-1:0] char_mem [DICT_ENTRIES];
  logic [LNKW-1:0] child_mem [DICT_ENTRIES];
  logic [LNKW-1:0] sib_mem [DICT_ENTRIES];

  // Root child links are reset as a group through these valid bits.
  logic [SYMBOL_COUNT-1:0] root_valid;

  lzw_pkg::state_t state, state_next;

  logic [IDXW-1:0] cursor;
  logic cursor_valid;
  logic [LNKW-1:0] next_free;
  logic [lzw_pkg::SYM_W-1:0] sym;
  logic is_final;
  logic head_ok;
  logic [LNKW-1:0] head_link;
  logic [IDXW-1:0] walk_idx;
  logic [LNKW-1:0] steps;

  logic [LNKW-1:0] child_q;
  logic [LNKW-1:0] sib_q;
  logic [lzw_pkg::SYM_W-1:0] char_q;

  logic [IDXW-1:0] child_raddr;
  logic [IDXW-1:0] walk_raddr;

  logic in_acc;
  logic sym_ok;
  logic out_free;
  logic [LNKW-1:0] head_eff;
  logic dict_full;
  logic cursor_is_root;
  logic walk_more;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign sym_ok = {1'b0, in_ch.symbol} < (lzw_pkg::SYM_W + 1)'(SYMBOL_COUNT);
  assign out_free = !out_ch.valid || out_ch.ready;
  assign head_eff = head_ok ? child_q : '0;
  assign dict_full = next_free >= LNKW'(DICT_ENTRIES);
  assign cursor_is_root = {1'b0, cursor} < (IDXW + 1)'(SYMBOL_COUNT);
  assign walk_more = sib_q[IDXW] && (steps < LNKW'(DICT_ENTRIES));

  assign in_ch.ready = (state == lzw_pkg::ST_IDLE);
  assign child_raddr = cursor;
  assign walk_raddr = (state == lzw_pkg::ST_HEAD) ? head_eff[IDXW-1:0] : sib_q[IDXW-1:0];

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      lzw_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.kind == lzw_pkg::KIND_FINISH) begin
            if (cursor_valid) state_next = lzw_pkg::ST_EMIT;
          end else if (sym_ok && cursor_valid) begin
            state_next = lzw_pkg::ST_HEAD;
          end
        end
      end
      lzw_pkg::ST_HEAD: begin
        state_next = head_eff[IDXW] ? lzw_pkg::ST_WALK : lzw_pkg::ST_EMIT;
      end
      lzw_pkg::ST_WALK: begin
        if (char_q == sym) state_next = lzw_pkg::ST_IDLE;
        else if (!walk_more) state_next = lzw_pkg::ST_EMIT;
      end
      lzw_pkg::ST_EMIT: begin
        if (out_free) begin
          state_next = (is_final || dict_full) ? lzw_pkg::ST_IDLE : lzw_pkg::ST_LINK;
        end
      end
      lzw_pkg::ST_LINK: state_next = lzw_pkg::ST_IDLE;
      default: state_next = lzw_pkg::ST_IDLE;
    endcase
  end

  // Memories: registered synchronous reads, writes on the emit and link steps.
  always_ff @(posedge clk) begin
    child_q <= child_mem[child_raddr];
    char_q <= char_mem[walk_raddr];
    sib_q <= sib_mem[walk_raddr];
    if (state == lzw_pkg::ST_EMIT && out_free && !is_final && !dict_full) begin
      char_mem[next_free[IDXW-1:0]] <= sym;
      sib_mem[next_free[IDXW-1:0]] <= head_link;
      child_mem[cursor] <= {1'b1, next_free[IDXW-1:0]};
    end else if (state == lzw_pkg::ST_LINK) begin
      child_mem[next_free[IDXW-1:0]] <= '0;
    end
  end

  // Datapath and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lzw_pkg::ST_IDLE;
      cursor <= '0;
      cursor_valid <= 1'b0;
      next_free <= LNKW'(SYMBOL_COUNT);
      root_valid <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      // The emit step loads a new word itself, so the clear is left to it there.
      if (out_ch.valid && out_ch.ready && state != lzw_pkg::ST_EMIT) out_ch.valid <= 1'b0;
      unique case (state)
        lzw_pkg::ST_IDLE: begin
          if (in_acc) begin
            sym <= in_ch.symbol;
            is_final <= (in_ch.kind == lzw_pkg::KIND_FINISH);
            head_ok <= !cursor_is_root || root_valid[cursor[RW-1:0]];
            if (in_ch.kind == lzw_pkg::KIND_DATA && sym_ok && !cursor_valid) begin
              cursor <= IDXW'(in_ch.symbol);
              cursor_valid <= 1'b1;
            end
          end
        end
        lzw_pkg::ST_HEAD: begin
          head_link <= head_eff;
          walk_idx <= head_eff[IDXW-1:0];
          steps <= LNKW'(1);
        end
        lzw_pkg::ST_WALK: begin
          if (char_q == sym) begin
            cursor <= walk_idx;
          end else begin
            walk_idx <= sib_q[IDXW-1:0];
            steps <= steps + LNKW'(1);
          end
        end
        lzw_pkg::ST_EMIT: begin
          if (out_free) begin
            out_ch.valid <= 1'b1;
            out_ch.code <= lzw_pkg::CODE_W'(cursor);
            out_ch.final_res <= is_final;
            if (!is_final) begin
              if (dict_full) begin
                root_valid <= '0;
                next_free <= LNKW'(SYMBOL_COUNT);
                cursor <= IDXW'(sym);
              end else if (cursor_is_root) begin
                root_valid[cursor[RW-1:0]] <= 1'b1;
              end
            end
          end
        end
        lzw_pkg::ST_LINK: begin
          next_free <= next_free + LNKW'(1);
          cursor <= IDXW'(sym);
        end
        default: ;
      endcase
    end
  end

endmodule

/* rtl/lzw_check.sv */
module lzw_check (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [lzw_pkg::CODE_W-1:0] out_code
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_code))
    else $error("stalled output word changed");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A new output word is only loaded while the input side is closed.
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("output word loaded while input was open");

endmodule

bind lzw_trie_encoder lzw_check u_lzw_check (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ch.ready),
  .out_valid(out_ch.valid),
  .out_ready(out_ch.ready),
  .out_code(out_ch.code)
);
